// ===== sv/dtf_pkg.sv =====
// dtf_pkg: shared types, parameter defaults, micro-op and condition codes,
// and the control store of the decimal text to fixed point converter.
// No dependencies.
package dtf_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 48;
  localparam int MANT_BITS_DEF  = 40;
  localparam int EXP_LIMIT_DEF  = 99;

  localparam int STEP_W = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 4;

  // datapath micro-ops
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_WAIT    = 4'd1;
  localparam logic [OP_W-1:0] OP_CHAR    = 4'd2;
  localparam logic [OP_W-1:0] OP_COMMIT  = 4'd3;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd5;
  localparam logic [OP_W-1:0] OP_DIVINIT = 4'd6;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 4'd7;
  localparam logic [OP_W-1:0] OP_EINC    = 4'd8;
  localparam logic [OP_W-1:0] OP_OUT     = 4'd9;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
  localparam logic [COND_W-1:0] C_NO_CHAR    = 4'd2;
  localparam logic [COND_W-1:0] C_MORE_CHARS = 4'd3;
  localparam logic [COND_W-1:0] C_LOAD_NEG   = 4'd4;
  localparam logic [COND_W-1:0] C_MUL_GO     = 4'd5;
  localparam logic [COND_W-1:0] C_DIV_STOP   = 4'd6;
  localparam logic [COND_W-1:0] C_DIV_MORE   = 4'd7;
  localparam logic [COND_W-1:0] C_OUT_FREE   = 4'd8;

  // program addresses
  localparam logic [STEP_W-1:0] S_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] S_CHAR     = 4'd1;
  localparam logic [STEP_W-1:0] S_COMMIT   = 4'd2;
  localparam logic [STEP_W-1:0] S_LOAD     = 4'd3;
  localparam logic [STEP_W-1:0] S_MUL      = 4'd4;
  localparam logic [STEP_W-1:0] S_MUL_END  = 4'd5;
  localparam logic [STEP_W-1:0] S_DIV_CHK  = 4'd6;
  localparam logic [STEP_W-1:0] S_DIV_STEP = 4'd7;
  localparam logic [STEP_W-1:0] S_E_INC    = 4'd8;
  localparam logic [STEP_W-1:0] S_OUT      = 4'd9;
  localparam logic [STEP_W-1:0] S_OUT_HOLD = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic char_valid;
    logic str_end;
    logic load_neg;
    logic mul_go;
    logic div_stop;
    logic div_more;
    logic out_free;
  } dp_status_t;

  // next step = cond ? target : step + 1
  function automatic uword_t ucode_word(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      S_WAIT:     w = '{OP_WAIT,    C_NO_CHAR,    S_WAIT};
      S_CHAR:     w = '{OP_CHAR,    C_MORE_CHARS, S_WAIT};
      S_COMMIT:   w = '{OP_COMMIT,  C_NEVER,      S_WAIT};
      S_LOAD:     w = '{OP_LOAD,    C_LOAD_NEG,   S_DIV_CHK};
      S_MUL:      w = '{OP_MUL,     C_MUL_GO,     S_MUL};
      S_MUL_END:  w = '{OP_NOP,     C_ALWAYS,     S_OUT};
      S_DIV_CHK:  w = '{OP_DIVINIT, C_DIV_STOP,   S_OUT};
      S_DIV_STEP: w = '{OP_DIVSTEP, C_DIV_MORE,   S_DIV_STEP};
      S_E_INC:    w = '{OP_EINC,    C_ALWAYS,     S_DIV_CHK};
      S_OUT:      w = '{OP_OUT,     C_OUT_FREE,   S_WAIT};
      S_OUT_HOLD: w = '{OP_NOP,     C_ALWAYS,     S_OUT};
      default:    w = '{OP_NOP,     C_ALWAYS,     S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/dtf_div10.sv =====
// dtf_div10: divides one byte, with the running remainder in front, by ten.
// Eight restoring steps on a 5-bit partial remainder. Uses no package.
module dtf_div10 (
  input  logic [3:0] rem,
  input  logic [7:0] din,
  output logic [7:0] quo,
  output logic [3:0] rem_next
);

  logic [3:0] r;
  logic [4:0] t;

  always_comb begin
    r   = rem;
    t   = '0;
    quo = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, din[i]};
      if (t >= 5'd10) begin
        quo[i] = 1'b1;
        r      = 4'(t - 5'd10);
      end else begin
        r = t[3:0];
      end
    end
    rem_next = r;
  end

endmodule

// ===== sv/dtf_sequencer.sv =====
// dtf_sequencer: step counter, control store lookup and jump logic.
// Depends on dtf_pkg.
module dtf_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  dtf_pkg::dp_status_t    status,
  output dtf_pkg::uword_t        ctrl
);
  import dtf_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              jump;

  assign ctrl = ucode_word(step);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_CHAR:    jump = !status.char_valid;
      C_MORE_CHARS: jump = !status.str_end;
      C_LOAD_NEG:   jump = status.load_neg;
      C_MUL_GO:     jump = status.mul_go;
      C_DIV_STOP:   jump = status.div_stop;
      C_DIV_MORE:   jump = status.div_more;
      C_OUT_FREE:   jump = status.out_free;
      default:      jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : STEP_W'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== sv/dtf_datapath.sv =====
// dtf_datapath: character parser registers, scaling register with x10 and /10
// units, and the result register. Driven by micro-ops from dtf_sequencer.
// Depends on dtf_pkg and dtf_div10.
module dtf_datapath #(
  parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = dtf_pkg::VALUE_BITS_DEF,
  parameter int MANT_BITS  = dtf_pkg::MANT_BITS_DEF,
  parameter int EXP_LIMIT  = dtf_pkg::EXP_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dtf_pkg::uword_t         ctrl,
  output dtf_pkg::dp_status_t     status,
  input  logic                    char_valid,
  input  logic [7:0]              char_code,
  input  logic                    last_char,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                    found,
  output logic                    saturated
);
  import dtf_pkg::*;

  // scaling register must hold mantissa << FRAC_BITS and limit * 10
  localparam int XW_A   = MANT_BITS + FRAC_BITS;
  localparam int XW_B   = VALUE_BITS + 4;
  localparam int XW     = (XW_A > XW_B) ? XW_A : XW_B;
  localparam int DW     = ((XW + 7) / 8) * 8;
  localparam int CHUNKS = DW / 8;
  localparam int CNT_W  = $clog2(CHUNKS);
  localparam int EW     = $clog2(EXP_LIMIT + 1);

  localparam logic [DW-1:0] LIM_NEG = DW'(1) << (VALUE_BITS - 1);
  localparam logic [DW-1:0] LIM_POS = LIM_NEG - DW'(1);

  localparam logic [MANT_BITS-1:0] MANT_MAX = '1;
  localparam logic [MANT_BITS-1:0] ROOM_MAX = (MANT_MAX - MANT_BITS'(9)) / MANT_BITS'(10);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_INT    = 3'd1;
  localparam logic [2:0] PH_FRAC   = 3'd2;
  localparam logic [2:0] PH_ESIGN  = 3'd3;
  localparam logic [2:0] PH_EPLUS  = 3'd4;
  localparam logic [2:0] PH_EMINUS = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  // parse state
  logic [2:0]           phase;
  logic [MANT_BITS-1:0] mantissa;
  logic                 is_negative;
  logic [4:0]           fraction_count;
  logic [EW-1:0]        exponent_accum;
  logic signed [8:0]    decimal_shift;
  logic                 number_seen;

  // work registers
  logic [7:0]           char_reg;
  logic                 last_reg;
  logic [DW-1:0]        x;
  logic signed [9:0]    e;
  logic [3:0]           rem;
  logic [CNT_W-1:0]     cnt;

  logic                 is_digit;
  logic                 is_e;
  logic [3:0]           d;
  logic                 room;
  logic [MANT_BITS-1:0] mant_x10;
  logic [EW+3:0]        exp_x10;
  logic [EW-1:0]        exp_next;
  logic signed [9:0]    acc_s;
  logic signed [9:0]    sh_delta;
  logic signed [9:0]    sh_sum;
  logic signed [8:0]    sh_clamped;
  logic                 ds_pos;
  logic signed [9:0]    e_load;
  logic [DW-1:0]        x_load;
  logic [DW-1:0]        x_x10;
  logic [DW-1:0]        limit;
  logic                 above;
  logic                 mul_go;
  logic                 out_free;
  logic [7:0]           q_byte;
  logic [3:0]           rem_next;
  logic [VALUE_BITS-1:0] mag;

  assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
  assign is_e     = (char_reg == CH_E_LO) || (char_reg == CH_E_UP);
  assign d        = 4'(char_reg - CH_ZERO);
  assign room     = (mantissa <= ROOM_MAX);
  assign mant_x10 = (mantissa << 3) + (mantissa << 1) + MANT_BITS'(d);

  assign exp_x10  = ({4'b0000, exponent_accum} << 3) + ({4'b0000, exponent_accum} << 1)
                    + (EW+4)'(d);
  assign exp_next = (exp_x10 > (EW+4)'(EXP_LIMIT)) ? EW'(EXP_LIMIT) : exp_x10[EW-1:0];

  // power-of-ten adjust: +1 for a dropped integer digit, else +/- exponent
  assign acc_s = $signed(10'(exponent_accum));
  always_comb begin
    if (phase == PH_INT) begin
      sh_delta = 10'sd1;
    end else if (phase == PH_EMINUS) begin
      sh_delta = -acc_s;
    end else begin
      sh_delta = acc_s;
    end
    sh_sum = $signed({decimal_shift[8], decimal_shift}) + sh_delta;
    if (sh_sum > 10'sd255) begin
      sh_clamped = 9'sd255;
    end else if (sh_sum < -10'sd256) begin
      sh_clamped = $signed(9'h100);
    end else begin
      sh_clamped = $signed(sh_sum[8:0]);
    end
  end

  assign ds_pos = !decimal_shift[8] && (decimal_shift != 9'sd0);

  assign e_load = $signed({decimal_shift[8], decimal_shift})
                  - $signed({5'b00000, fraction_count});
  assign x_load = DW'(mantissa) << FRAC_BITS;
  assign x_x10  = (x << 3) + (x << 1);
  assign limit  = is_negative ? LIM_NEG : LIM_POS;
  assign above  = (x > limit);
  assign mul_go = !e[9] && (e != 10'sd0) && !above;
  assign out_free = !result_valid || !result_stall;
  assign mag    = above ? limit[VALUE_BITS-1:0] : x[VALUE_BITS-1:0];

  dtf_div10 u_div10 (
    .rem      (rem),
    .din      (x[DW-1 -: 8]),
    .quo      (q_byte),
    .rem_next (rem_next)
  );

  assign status.char_valid = char_valid;
  assign status.str_end    = (char_reg == CH_NUL) || last_reg;
  assign status.load_neg   = e_load[9];
  assign status.mul_go     = mul_go;
  assign status.div_stop   = !e[9] || (x == '0);
  assign status.div_more   = (cnt != CNT_W'(CHUNKS - 1));
  assign status.out_free   = out_free;

  // parse state: advanced once per character, exponent closed at commit, cleared at output
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SKIP;
      mantissa       <= '0;
      is_negative    <= 1'b0;
      fraction_count <= '0;
      exponent_accum <= '0;
      decimal_shift  <= '0;
      number_seen    <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_CHAR: begin
          if (char_reg != CH_NUL) begin
            unique case (phase)
              PH_SKIP: begin
                if (is_digit) begin
                  number_seen <= 1'b1;
                  phase       <= PH_INT;
                  mantissa    <= MANT_BITS'(d);
                end else if (char_reg == CH_MINUS) begin
                  number_seen <= 1'b1;
                  is_negative <= 1'b1;
                  phase       <= PH_INT;
                end
              end
              PH_INT: begin
                if (is_digit) begin
                  if (room) begin
                    mantissa <= mant_x10;
                  end else begin
                    decimal_shift <= sh_clamped;
                  end
                end else if (char_reg == CH_DOT) begin
                  phase <= PH_FRAC;
                end else if (is_e) begin
                  phase <= PH_ESIGN;
                end else begin
                  phase <= PH_DONE;
                end
              end
              PH_FRAC: begin
                if (is_digit) begin
                  if (room && (fraction_count != 5'd31) && !ds_pos) begin
                    mantissa       <= mant_x10;
                    fraction_count <= fraction_count + 5'd1;
                  end
                end else if (is_e) begin
                  phase <= PH_ESIGN;
                end else begin
                  phase <= PH_DONE;
                end
              end
              PH_ESIGN: begin
                if (char_reg == CH_PLUS) begin
                  phase <= PH_EPLUS;
                end else if (char_reg == CH_MINUS) begin
                  phase <= PH_EMINUS;
                end else begin
                  phase <= PH_DONE;
                end
              end
              PH_EPLUS: begin
                if (is_digit) begin
                  exponent_accum <= exp_next;
                end else begin
                  decimal_shift  <= sh_clamped;
                  exponent_accum <= '0;
                  phase <= (char_reg == CH_MINUS) ? PH_EMINUS : PH_DONE;
                end
              end
              PH_EMINUS: begin
                if (is_digit) begin
                  exponent_accum <= exp_next;
                end else begin
                  decimal_shift  <= sh_clamped;
                  exponent_accum <= '0;
                  phase          <= PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        OP_COMMIT: begin
          // string ended inside an exponent
          if ((phase == PH_EPLUS) || (phase == PH_EMINUS)) begin
            decimal_shift  <= sh_clamped;
            exponent_accum <= '0;
          end
        end
        OP_OUT: begin
          if (out_free) begin
            phase          <= PH_SKIP;
            mantissa       <= '0;
            is_negative    <= 1'b0;
            fraction_count <= '0;
            exponent_accum <= '0;
            decimal_shift  <= '0;
            number_seen    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // work and result payload
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_WAIT: begin
        if (char_valid) begin
          char_reg <= char_code;
          last_reg <= last_char;
        end
      end
      OP_LOAD: begin
        x <= x_load;
        e <= e_load;
      end
      OP_MUL: begin
        if (mul_go) begin
          x <= x_x10;
          e <= e - 10'sd1;
        end
      end
      OP_DIVINIT: begin
        rem <= '0;
        cnt <= '0;
      end
      OP_DIVSTEP: begin
        // quotient bytes rotate in at the bottom as dividend bytes leave the top
        x   <= {x[DW-9:0], q_byte};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
      end
      OP_EINC: begin
        e <= e + 10'sd1;
      end
      OP_OUT: begin
        if (out_free) begin
          value     <= is_negative ? $signed(VALUE_BITS'(0) - mag) : $signed(mag);
          found     <= number_seen;
          saturated <= above;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((ctrl.op == OP_OUT) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/decimal_text_to_fixed_point_top.sv =====
// Channel  Dir  Handshake                    Word
// char     in   char_valid / char_stall      char_code[7:0], last_char
// result   out  result_valid / result_stall  value[VALUE_BITS-1:0], found, saturated
//
// A character is taken in the wait step, then handled in the parser step.
// At string end (NUL or last_char): commit, load, x10 or /10 steps, then output; each
// /10 step runs the byte-wide /10 unit over all DW/8 bytes of the scaling register.
// Reset (rst, synchronous) returns the sequencer to its wait step and clears
// the parser. A stalled result holds in the output register; characters of
// the next string are still taken meanwhile, the next result waits for it.
// Top level of the decimal text to fixed point converter.
// Depends on dtf_pkg, dtf_sequencer, dtf_datapath.
module decimal_text_to_fixed_point_top #(
  parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = dtf_pkg::VALUE_BITS_DEF,
  parameter int MANT_BITS  = dtf_pkg::MANT_BITS_DEF,
  parameter int EXP_LIMIT  = dtf_pkg::EXP_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_stall,
  input  logic [7:0]                   char_code,
  input  logic                         last_char,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                         found,
  output logic                         saturated
);
  import dtf_pkg::*;

  uword_t     ctrl;
  dp_status_t status;

  dtf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  dtf_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_BITS (VALUE_BITS),
    .MANT_BITS  (MANT_BITS),
    .EXP_LIMIT  (EXP_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .char_valid   (char_valid),
    .char_code    (char_code),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .found        (found),
    .saturated    (saturated)
  );

  assign char_stall = (ctrl.op != OP_WAIT);

`ifndef NO_ASSERTIONS
  a_char_then_parse: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall) |=> (ctrl.op == OP_CHAR))
    else $error("accepted char word not followed by parser step");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctrl.op == OP_OUT))
    else $error("result raised outside the output step");

  a_sat_needs_found: assert property (@(posedge clk) disable iff (rst)
    (result_valid && saturated) |-> found)
    else $error("saturated result without a number");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> ((value == '0) && !saturated))
    else $error("empty string gave nonzero result");
`endif

endmodule

// ===== tb/sv/dtf_reading_checker.sv =====
`timescale 1ns / 100ps
// Checker for decimal_text_to_fixed_point_top: predicts the reading that each
// string produces and compares it with every result word. Depends on dtf_pkg.
module dtf_reading_checker #(
  parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF,
  parameter int VALUE_BITS = dtf_pkg::VALUE_BITS_DEF,
  parameter int MANT_BITS  = dtf_pkg::MANT_BITS_DEF,
  parameter int EXP_LIMIT  = dtf_pkg::EXP_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  input  logic                         char_stall,
  input  logic [7:0]                   char_code,
  input  logic                         last_char,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         found,
  input  logic                         saturated,
  output int                           mismatches,
  output int                           pending
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_E_LO  = "e";
  localparam logic [7:0] CH_E_UP  = "E";

  localparam int          FRAC_KEEP_MAX = 31;
  localparam int          SHIFT_MAX     = 255;
  localparam int          SHIFT_MIN     = -256;
  localparam logic [63:0] MANT_ROOM     = (((64'd1 << MANT_BITS) - 64'd1) - 64'd9) / 64'd10;

  typedef enum logic [2:0] {
    P_SKIP, P_INT, P_FRAC, P_ESIGN, P_EPLUS, P_EMINUS, P_DONE
  } parse_phase_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic                         found;
    logic                         saturated;
  } reading_t;

  parse_phase_t phase;
  logic [63:0]  mantissa;
  logic         negative;
  int           frac_digits;
  int           exp_accum;
  int           pow10_shift;
  logic         number_seen;

  reading_t readings_due[$];

  function automatic void clear_parser();
    phase       = P_SKIP;
    mantissa    = '0;
    negative    = 1'b0;
    frac_digits = 0;
    exp_accum   = 0;
    pow10_shift = 0;
    number_seen = 1'b0;
  endfunction

  function automatic void add_shift(input int d);
    int s;
    s = pow10_shift + d;
    if (s > SHIFT_MAX) s = SHIFT_MAX;
    if (s < SHIFT_MIN) s = SHIFT_MIN;
    pow10_shift = s;
  endfunction

  function automatic void commit_exponent(input logic neg);
    add_shift(neg ? -exp_accum : exp_accum);
    exp_accum = 0;
  endfunction

  function automatic void exp_digit(input int d);
    int v;
    v = exp_accum * 10 + d;
    exp_accum = (v > EXP_LIMIT) ? EXP_LIMIT : v;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic is_digit;
    int   d;
    is_digit = (c >= CH_0) && (c <= CH_9);
    d = is_digit ? int'(c - CH_0) : 0;
    case (phase)
      P_SKIP: begin
        if (is_digit) begin
          number_seen = 1'b1;
          phase       = P_INT;
          mantissa    = 64'(d);
        end else if (c == CH_MINUS) begin
          number_seen = 1'b1;
          negative    = 1'b1;
          phase       = P_INT;
        end
      end
      P_INT: begin
        if (is_digit) begin
          // full mantissa: integer digits only scale
          if (mantissa <= MANT_ROOM) mantissa = mantissa * 64'd10 + 64'(d);
          else add_shift(1);
        end else if (c == CH_DOT) phase = P_FRAC;
        else if (c == CH_E_LO || c == CH_E_UP) phase = P_ESIGN;
        else phase = P_DONE;
      end
      P_FRAC: begin
        if (is_digit) begin
          if (mantissa <= MANT_ROOM && frac_digits < FRAC_KEEP_MAX && pow10_shift <= 0) begin
            mantissa    = mantissa * 64'd10 + 64'(d);
            frac_digits = frac_digits + 1;
          end
        end else if (c == CH_E_LO || c == CH_E_UP) phase = P_ESIGN;
        else phase = P_DONE;
      end
      P_ESIGN: begin
        if (c == CH_PLUS) phase = P_EPLUS;
        else if (c == CH_MINUS) phase = P_EMINUS;
        else phase = P_DONE;
      end
      P_EPLUS: begin
        if (is_digit) exp_digit(d);
        else begin
          commit_exponent(1'b0);
          phase = (c == CH_MINUS) ? P_EMINUS : P_DONE;
        end
      end
      P_EMINUS: begin
        if (is_digit) exp_digit(d);
        else begin
          commit_exponent(1'b1);
          phase = P_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic reading_t close_string();
    reading_t     r;
    logic [127:0] x;
    logic [127:0] lim;
    logic [127:0] mag;
    logic         sat;
    int           e;
    if (phase == P_EPLUS) commit_exponent(1'b0);
    else if (phase == P_EMINUS) commit_exponent(1'b1);
    lim = (128'd1 << (VALUE_BITS - 1)) - (negative ? 128'd0 : 128'd1);
    x = 128'(mantissa) << FRAC_BITS;
    e = pow10_shift - frac_digits;
    // scale up until the exponent is used or past the limit, or down until it is used or nothing is left
    while (e > 0 && x <= lim) begin
      x = x * 128'd10;
      e = e - 1;
    end
    while (e < 0 && x != 128'd0) begin
      x = x / 128'd10;
      e = e + 1;
    end
    sat = x > lim;
    mag = sat ? lim : x;
    r.value     = negative ? VALUE_BITS'(128'd0 - mag) : VALUE_BITS'(mag);
    r.found     = number_seen;
    r.saturated = sat;
    clear_parser();
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      clear_parser();
      readings_due.delete();
      mismatches = 0;
    end else begin
      if (char_valid && !char_stall) begin
        if (char_code != CH_NUL) take_char(char_code);
        if (char_code == CH_NUL || last_char) readings_due.push_back(close_string());
      end
      if (result_valid && !result_stall) begin
        if (readings_due.size() == 0) begin
          $display("%0t unexpected result word: value %0d found %0b saturated %0b",
                   $time, value, found, saturated);
          mismatches = mismatches + 1;
        end else begin
          want = readings_due.pop_front();
          if (value !== want.value) begin
            $display("%0t value mismatch: expected %0d, actual %0d", $time, want.value, value);
            mismatches = mismatches + 1;
          end
          if (found !== want.found) begin
            $display("%0t found mismatch: expected %0b, actual %0b", $time, want.found, found);
            mismatches = mismatches + 1;
          end
          if (saturated !== want.saturated) begin
            $display("%0t saturated mismatch: expected %0b, actual %0b",
                     $time, want.saturated, saturated);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    pending = readings_due.size();
  end

endmodule

// ===== tb/sv/decimal_text_to_fixed_point_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for decimal_text_to_fixed_point_top: feeds directed and random
// strings, stalls the result side, and reports the verdict.
// Depends on dtf_pkg, the block and dtf_reading_checker.
module decimal_text_to_fixed_point_top_tb;

  localparam int VALUE_BITS  = dtf_pkg::VALUE_BITS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_E_LO  = "e";
  localparam logic [7:0] CH_E_UP  = "E";

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         char_valid = 1'b0;
  logic                         char_stall;
  logic [7:0]                   char_code = 8'h00;
  logic                         last_char = 1'b0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic signed [VALUE_BITS-1:0] value;
  logic                         found;
  logic                         saturated;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int chars_sent;
  int quiet_cycles;

  // {last, code} per word of the string being built
  logic [8:0] text_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  decimal_text_to_fixed_point_top dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .found        (found),
    .saturated    (saturated)
  );

  dtf_reading_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .found        (found),
    .saturated    (saturated),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push(input logic [7:0] c);
    text_q.push_back({1'b0, c});
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push(s[i]);
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  // anything that the skip phase passes over
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1));
    while ((c >= CH_0 && c <= CH_9) || c == CH_MINUS);
    return c;
  endfunction

  function automatic int run_len(input int short_max, input int long_max);
    return ($urandom_range(9) == 0) ? $urandom_range(long_max, 10) : $urandom_range(short_max);
  endfunction

  function automatic void push_digits(input int n);
    repeat (n) push(digit_char());
  endfunction

  function automatic int exp_len();
    return ($urandom_range(9) == 0) ? $urandom_range(4, 2) : $urandom_range(1);
  endfunction

  // end with NUL, or mark the final word last
  function automatic void terminate(input logic use_nul, input logic nul_last);
    if (use_nul || text_q.size() == 0) text_q.push_back({nul_last, CH_NUL});
    else text_q[text_q.size() - 1][8] = 1'b1;
  endfunction

  function automatic void make_string();
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(2)) push(junk_char());
      if ($urandom_range(1)) push(CH_MINUS);
      push_digits(run_len(6, 25));
      if ($urandom_range(99) < 60) begin
        push(CH_DOT);
        push_digits(run_len(6, 40));
      end
      if ($urandom_range(99) < 40) begin
        push($urandom_range(1) ? CH_E_LO : CH_E_UP);
        case ($urandom_range(4))
          0: begin
            push(CH_PLUS);
            push_digits(exp_len());
          end
          1: begin
            push(CH_PLUS);
            push_digits(exp_len());
            push(CH_MINUS);
            push_digits(exp_len());
          end
          2, 3: begin
            push(CH_MINUS);
            push_digits(exp_len());
          end
          default: ;
        endcase
      end
      repeat ($urandom_range(3)) push(8'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(8, 1)) push(8'($urandom_range(255, 1)));
    end
    terminate($urandom_range(99) < 30, 1'($urandom_range(1)));
  endfunction

  task automatic send_text();
    logic [8:0] w;
    while (text_q.size() != 0) begin
      w = text_q.pop_front();
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        char_valid <= 1'b0;
        char_code  <= 8'($urandom_range(255));
        last_char  <= 1'($urandom_range(1));
        @(negedge clk);
      end
      char_valid <= 1'b1;
      char_code  <= w[7:0];
      last_char  <= w[8];
      do @(posedge clk); while (char_stall);
      chars_sent = chars_sent + 1;
    end
  endtask

  task automatic directed_string(input string s, input logic use_nul, input logic nul_last);
    push_text(s);
    terminate(use_nul, nul_last);
    send_text();
  endtask

  task automatic random_strings(input int upto);
    while (chars_sent < upto) begin
      make_string();
      send_text();
    end
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 74;
    chars_sent    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_string("", 1'b1, 1'b0);         // NUL alone: nothing found
    push(8'hFF);                             // all-ones byte, then end
    directed_string("", 1'b0, 1'b0);
    directed_string("-", 1'b0, 1'b0);        // lone minus
    directed_string("-0", 1'b1, 1'b1);       // negative zero
    directed_string("1.5e+2-1", 1'b0, 1'b0); // plus then minus exponent
    directed_string("9e-", 1'b1, 1'b0);      // empty exponent
    directed_string("7e", 1'b0, 1'b0);       // bare e
    directed_string("-8e+999", 1'b0, 1'b0);  // exponent clamp, negative saturation

    random_strings(300);
    send_idle_pct = 74;
    recv_idle_pct = 29;
    random_strings(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_strings(900);

    @(negedge clk);
    char_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dtf_pkg.sv
sv/dtf_div10.sv
sv/dtf_sequencer.sv
sv/dtf_datapath.sv
sv/decimal_text_to_fixed_point_top.sv
tb/sv/dtf_reading_checker.sv
tb/sv/decimal_text_to_fixed_point_top_tb.sv
